// ===== src/torus_mesh_vertex_generator_assert.svh =====
// Assertion macros for the torus mesh vertex generator.
`ifndef TORUS_MESH_VERTEX_GENERATOR_ASSERT_SVH
`define TORUS_MESH_VERTEX_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on the rising clock edge, ignored while reset is held.
`define TMVG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the rising clock edge, reset included.
`define TMVG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMVG_ASSERT(lbl, clk, rstn, prop, msg)
`define TMVG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/tmvg_pkg.sv =====
// Package of the torus mesh vertex generator: widths, register codes, trig and rounding functions.
`default_nettype none
package tmvg_pkg;

    localparam int DEF_SLICE_COUNT = 40;
    localparam int DEF_RING_COUNT  = 40;

    localparam int NUM_W   = 6;   // slice and ring number width
    localparam int RAD_W   = 16;  // radius width, unsigned Q8.8
    localparam int COORD_W = 16;  // coordinate width, signed Q8.8
    localparam int TRIG_W  = 16;  // sine and cosine, signed Q1.14
    localparam int IDX_W   = 11;  // vertex index width
    localparam int CFG_IDX_W = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 144;
    localparam int ACC_W     = 48; // exact coordinate before rounding

    localparam logic [RAD_W-1:0] INNER_RESET = 16'd256;
    localparam logic [RAD_W-1:0] OUTER_RESET = 16'd512;

    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 8'd1;

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Sine (upper half) and cosine (lower half) in Q1.14 of a phase up to 1/8 turn.
    function automatic logic [31:0] octant_trig(input logic [13:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        x  = (64'(r) * TWO_PI_Q30) >> 16;
        x2 = (x * x) >> 30;
        t = Q30_ONE - x2 / 64'd42;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s = (((x * t) >> 30) + 64'd32768) >> 16;
        t = Q30_ONE - x2 / 64'd56;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
        c = (t + 64'd32768) >> 16;
        return {s[15:0], c[15:0]};
    endfunction

    // Sine (upper half) and cosine (lower half) of a phase in 1/65536 turn.
    function automatic logic [31:0] angle_trig(input logic [15:0] p);
        logic [1:0]  quad;
        logic [13:0] r;
        logic [31:0] oc;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        quad = p[15:14];
        r    = p[13:0];
        if (r <= 14'd8192) begin
            oc = octant_trig(r);
            a  = oc[31:16];
            b  = oc[15:0];
        end else begin
            oc = octant_trig(14'(15'd16384 - 15'(r)));
            b  = oc[31:16];
            a  = oc[15:0];
        end
        unique case (quad)
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
        return {sn, cs};
    endfunction

    // Round a value with 29 extra fraction bits to nearest Q8.8, halves up, saturating.
    function automatic logic [COORD_W-1:0] to_q8_8(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0] w;
        logic signed [ACC_W:0] sh;
        logic signed [19:0]    r;
        w  = {v[ACC_W-1], v} + 49'sd268435456;
        sh = w >>> 29;
        r  = sh[19:0];
        if (r > 20'sd32767) begin
            return 16'h7FFF;
        end else if (r < -20'sd32768) begin
            return 16'h8000;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/torus_mesh_vertex_generator.sv =====
// Torus mesh vertex generator: grid point in, vertex position, normal and indices out.
//
//   channel | dir | handshake                | payload
//   s_      | in  | s_tvalid / s_tready      | s_tdata: slice_number, ring_number
//   m_      | out | m_tvalid / m_tready      | m_tdata: position, normal, four indices
//   cfg_    | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data (radius write)
//
// One grid point is taken per cycle while no stall on m_ backs up the pipeline.
// Depth is set by four stages: table lookup, radius products, angle products, round.
// Reset (aresetn low, synchronous) empties the pipeline and loads the reset radii.
// A stall on m_ holds the stage that waits; empty stages in front keep filling.
`default_nettype none
module torus_mesh_vertex_generator #(
    parameter int SLICE_COUNT = tmvg_pkg::DEF_SLICE_COUNT,
    parameter int RING_COUNT  = tmvg_pkg::DEF_RING_COUNT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata from bit 0: slice_number[5:0], ring_number[11:6], zero pad [15:12]
    input  wire logic [tmvg_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata from bit 0: position_x, position_y, position_z, normal_x, normal_y,
    // normal_z (16 each), index_self, index_next_slice, index_diagonal,
    // index_next_ring (11 each), zero pad [143:140]
    output logic [tmvg_pkg::M_DATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tmvg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tmvg_pkg::RAD_W-1:0]          cfg_data
);
    import tmvg_pkg::*;

    localparam int SLICE_W = $clog2(SLICE_COUNT);
    localparam int RING_W  = $clog2(RING_COUNT);
    localparam int NUM_VALS = 2 ** NUM_W;
    localparam int PROD1_W  = 34;   // radius times Q1.14
    localparam int PROD2_W  = PROD1_W + TRIG_W;

    // ---------------- configuration registers ----------------
    logic [RAD_W-1:0] inner_reg;
    logic [RAD_W-1:0] outer_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg <= INNER_RESET;
            outer_reg <= OUTER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_INNER_RADIUS) begin
                inner_reg <= cfg_data;
            end
            if (cfg_index == REG_OUTER_RADIUS) begin
                outer_reg <= cfg_data;
            end
        end
    end

    // ---------------- constant tables ----------------
    logic [SLICE_W-1:0]       slice_mod [NUM_VALS];
    logic [RING_W-1:0]        ring_mod  [NUM_VALS];
    logic signed [TRIG_W-1:0] yaw_sin   [SLICE_COUNT];
    logic signed [TRIG_W-1:0] yaw_cos   [SLICE_COUNT];
    logic signed [TRIG_W-1:0] pitch_sin [RING_COUNT];
    logic signed [TRIG_W-1:0] pitch_cos [RING_COUNT];

    for (genvar v = 0; v < NUM_VALS; v++) begin : g_mod
        localparam int unsigned SM = v % SLICE_COUNT;
        localparam int unsigned RM = v % RING_COUNT;
        assign slice_mod[v] = SM[SLICE_W-1:0];
        assign ring_mod[v]  = RM[RING_W-1:0];
    end

    for (genvar k = 0; k < SLICE_COUNT; k++) begin : g_yaw
        localparam int unsigned PHASE = (k * 65536 + SLICE_COUNT / 2) / SLICE_COUNT;
        localparam logic [31:0] SC = angle_trig(PHASE[15:0]);
        assign yaw_sin[k] = SC[31:16];
        assign yaw_cos[k] = SC[15:0];
    end

    for (genvar k = 0; k < RING_COUNT; k++) begin : g_pitch
        localparam int unsigned PHASE = (k * 65536 + RING_COUNT / 2) / RING_COUNT;
        localparam logic [31:0] SC = angle_trig(PHASE[15:0]);
        assign pitch_sin[k] = SC[31:16];
        assign pitch_cos[k] = SC[15:0];
    end

    // ---------------- stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: reduce, look up, index ----------------
    logic [SLICE_W-1:0] slice_in, slice_nx;
    logic [RING_W-1:0]  ring_in, ring_nx;
    logic [SLICE_W-1:0] slice_reg;
    logic [RING_W-1:0]  ring_reg;
    logic signed [TRIG_W-1:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [RAD_W+1:0]  diff_reg, sum_reg;
    logic [4*IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx1_next;

    assign slice_in = slice_mod[s_tdata[NUM_W-1:0]];
    assign ring_in  = ring_mod[s_tdata[2*NUM_W-1:NUM_W]];
    assign slice_nx = (slice_in == SLICE_W'(SLICE_COUNT - 1)) ? '0 : slice_in + 1'b1;
    assign ring_nx  = (ring_in == RING_W'(RING_COUNT - 1)) ? '0 : ring_in + 1'b1;

    // Pack indices: self, next slice, diagonal, next ring from the low end
    assign idx1_next = {IDX_W'(slice_in * RING_COUNT + ring_nx),
                        IDX_W'(slice_nx * RING_COUNT + ring_nx),
                        IDX_W'(slice_nx * RING_COUNT + ring_in),
                        IDX_W'(slice_in * RING_COUNT + ring_in)};

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            slice_reg <= slice_in;
            ring_reg  <= ring_in;
            sy_reg    <= yaw_sin[slice_in];
            cy_reg    <= yaw_cos[slice_in];
            sp_reg    <= pitch_sin[ring_in];
            cp_reg    <= pitch_cos[ring_in];
            diff_reg  <= $signed({2'b00, outer_reg}) - $signed({2'b00, inner_reg});
            sum_reg   <= $signed({2'b00, outer_reg}) + $signed({2'b00, inner_reg});
            idx1_reg  <= idx1_next;
        end
    end

    // ---------------- stage 2: radius products ----------------
    logic signed [PROD1_W-1:0] dcy_reg, dsy_reg, dsp_reg, scy_reg, ssy_reg;
    logic signed [TRIG_W-1:0]  cp2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            dcy_reg  <= PROD1_W'(diff_reg * cy_reg);
            dsy_reg  <= PROD1_W'(diff_reg * sy_reg);
            dsp_reg  <= PROD1_W'(diff_reg * sp_reg);
            scy_reg  <= PROD1_W'(sum_reg * cy_reg);
            ssy_reg  <= PROD1_W'(sum_reg * sy_reg);
            cp2_reg  <= cp_reg;
            idx2_reg <= idx1_reg;
        end
    end

    // ---------------- stage 3: pitch products and scaling ----------------
    logic signed [ACC_W-1:0] nx_reg, ny_reg, nz_reg, bx_reg, bz_reg;
    logic signed [PROD2_W-1:0] nx_full, nz_full;

    assign nx_full = PROD2_W'(dcy_reg * cp2_reg);
    assign nz_full = PROD2_W'(dsy_reg * cp2_reg);

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            nx_reg   <= nx_full[ACC_W-1:0];
            nz_reg   <= nz_full[ACC_W-1:0];
            ny_reg   <= ACC_W'(dsp_reg) <<< 14;
            bx_reg   <= ACC_W'(scy_reg) <<< 14;
            bz_reg   <= ACC_W'(ssy_reg) <<< 14;
            idx3_reg <= idx2_reg;
        end
    end

    // ---------------- stage 4: sum, round, output word ----------------
    logic [M_DATA_W-1:0] out_reg;
    logic [M_DATA_W-1:0] out_next;
    logic signed [ACC_W-1:0] px_sum, pz_sum;

    assign px_sum = bx_reg + nx_reg;
    assign pz_sum = bz_reg + nz_reg;

    assign out_next = {4'b0000, idx3_reg,
                       to_q8_8(nz_reg), to_q8_8(ny_reg), to_q8_8(nx_reg),
                       to_q8_8(pz_sum), to_q8_8(ny_reg), to_q8_8(px_sum)};

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

    // ---------------- assertions ----------------
    `include "torus_mesh_vertex_generator_assert.svh"

    `TMVG_ASSERT(a_empty_front_takes, aclk, aresetn, !v1_reg |-> s_tready, "empty stage 1 refused a word")
    `TMVG_ASSERT(a_out_hold, aclk, aresetn, (v4_reg && !m_tready) |=> (v4_reg && $stable(out_reg)), "stalled result lost or changed")
    `TMVG_ASSERT(a_ring_range, aclk, aresetn, v1_reg |-> (ring_reg < RING_W'(RING_COUNT - 1) || ring_reg == RING_W'(RING_COUNT - 1)), "ring index out of range")
    `TMVG_ASSERT(a_slice_range, aclk, aresetn, v1_reg |-> (slice_reg < SLICE_W'(SLICE_COUNT - 1) || slice_reg == SLICE_W'(SLICE_COUNT - 1)), "slice index out of range")

endmodule
`default_nettype wire
